/* hw/rtl/dap_pkg.sv */
// Package for the decimal amount parser: payload structs, status codes,
// character codes and the power-of-ten helper. No dependencies.
`default_nettype none

package dap_pkg;

  // Default configuration of the fixed-point format.
  localparam int FRAC_DIGITS_DEF      = 8;
  localparam int MAX_WHOLE_DIGITS_DEF = 14;

  // Width of the amount field and of the internal accumulator. Until
  // overflow is flagged the accumulator holds at most 2^63 - 1 between items,
  // and one step (times ten plus a scaled digit) stays below 2^68.
  localparam int AMT_W = 63;
  localparam int ACC_W = 68;

  // Character codes.
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_OVERFLOW = 2'd3
  } dap_status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       terminator;
  } dap_in_t;

  typedef struct packed {
    dap_status_t      status;
    logic [AMT_W-1:0] amount;
  } dap_out_t;

  // Ten to the power n, for small constant n.
  function automatic logic [ACC_W-1:0] pow10(input int n);
    logic [ACC_W-1:0] v;
    v = ACC_W'(1);
    for (int i = 0; i < n; i++) begin
      v = ACC_W'(v * ACC_W'(10));
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/decimal_amount_parser.sv */
// Decimal amount parser top level: character-serial parse of a decimal
// string into a fixed-point amount. Depends on dap_pkg.
`default_nettype none

// The block takes an amount string one character per transfer and returns
// one result transfer when a transfer marked as terminator arrives. Leading
// white space (bytes 9 to 13 and 32) is skipped, then come whole digits, an
// optional point with up to FRAC_DIGITS fraction digits, and trailing white
// space. The result is whole * 10^FRAC_DIGITS plus the fraction units, in
// units of 10^-FRAC_DIGITS. Status 1 reports a bad character (including a
// second point, a digit after trailing space, or one fraction digit too
// many), status 2 more than MAX_WHOLE_DIGITS whole digits, and status 3 a
// value above 2^63 - 1; the amount is zero unless the status is 0. Each
// character updates a scaled accumulator with one add, after a multiply by
// ten for a whole digit, so a character can be accepted on every clock, save
// a terminator while a result waits. The terminator loads the result
// register as it is accepted; the result is on the output the cycle after.
// Ordinary characters are accepted even while a result waits on the output;
// only a terminator waits until the output register is free or being taken.
// The parse state returns to its reset values after each terminator.
module decimal_amount_parser #(
  parameter int FRAC_DIGITS      = dap_pkg::FRAC_DIGITS_DEF,
  parameter int MAX_WHOLE_DIGITS = dap_pkg::MAX_WHOLE_DIGITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire dap_pkg::dap_in_t in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      dap_pkg::dap_out_t out_data
);

  localparam int ACC_W = dap_pkg::ACC_W;
  localparam int AMT_W = dap_pkg::AMT_W;
  // The whole-digit count saturates at MAX_WHOLE_DIGITS + 1.
  localparam int WC_W  = $clog2(MAX_WHOLE_DIGITS + 2);
  localparam int FU_W  = $clog2(FRAC_DIGITS + 1);
  localparam logic [ACC_W-1:0] SCALE = dap_pkg::pow10(FRAC_DIGITS);

  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_WHOLE = 5'b00010,
    PH_FRAC  = 5'b00100,
    PH_TRAIL = 5'b01000,
    PH_ERR   = 5'b10000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  // The accumulator holds whole * 10^FRAC_DIGITS plus the fraction units
  // taken so far. Once it passes 2^63 - 1 the sticky overflow flag is set
  // and its contents no longer matter.
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [WC_W-1:0]   whole_count_r, whole_count_nxt;
  logic [FU_W-1:0]   frac_used_r, frac_used_nxt;

  logic              out_valid_r;
  dap_pkg::dap_out_t out_data_r;
  dap_pkg::dap_out_t result;

  logic              in_fire;
  logic              is_blank;
  logic              is_digit;
  logic              is_point;
  logic [ACC_W-1:0]  digit;
  logic [ACC_W-1:0]  place;
  logic [ACC_W-1:0]  whole_sum;
  logic [ACC_W-1:0]  frac_sum;

  // A terminator needs the output register; other characters do not.
  assign in_ready = !in_data.terminator || !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_blank = (in_data.ch == dap_pkg::CH_SPACE) ||
                    ((in_data.ch >= dap_pkg::CH_TAB) && (in_data.ch <= dap_pkg::CH_CR));
  assign is_digit = (in_data.ch >= dap_pkg::CH_ZERO) && (in_data.ch <= dap_pkg::CH_NINE);
  assign is_point = (in_data.ch == dap_pkg::CH_POINT);
  assign digit    = ACC_W'(in_data.ch[3:0]);

  // Weight of the next fraction digit: 10^(FRAC_DIGITS - 1 - frac_used).
  always_comb begin
    place = '0;
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      if (frac_used_r == FU_W'(k)) begin
        place = dap_pkg::pow10(FRAC_DIGITS - 1 - k);
      end
    end
  end

  // Times ten is a pair of shifts; the digit scale is a constant multiply.
  assign whole_sum = (acc_r << 3) + (acc_r << 1) + ACC_W'(digit * SCALE);
  assign frac_sum  = acc_r + ACC_W'(digit * place);

  always_comb begin
    phase_nxt       = phase_r;
    acc_nxt         = acc_r;
    ovf_nxt         = ovf_r;
    whole_count_nxt = whole_count_r;
    frac_used_nxt   = frac_used_r;
    if (in_fire) begin
      if (in_data.terminator) begin
        phase_nxt       = PH_LEAD;
        acc_nxt         = '0;
        ovf_nxt         = 1'b0;
        whole_count_nxt = '0;
        frac_used_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_LEAD, PH_WHOLE: begin
            if (is_point) begin
              phase_nxt = PH_FRAC;
            end else if (is_blank) begin
              phase_nxt = (phase_r == PH_LEAD) ? PH_LEAD : PH_TRAIL;
            end else if (is_digit) begin
              phase_nxt = PH_WHOLE;
              // Digits past the limit are dropped; the count saturates.
              if (whole_count_r <= WC_W'(MAX_WHOLE_DIGITS)) begin
                acc_nxt         = whole_sum;
                ovf_nxt         = ovf_r || (|whole_sum[ACC_W-1:AMT_W]);
                whole_count_nxt = whole_count_r + WC_W'(1);
              end
            end else begin
              phase_nxt = PH_ERR;
            end
          end
          PH_FRAC: begin
            if (is_digit && (frac_used_r < FU_W'(FRAC_DIGITS))) begin
              acc_nxt       = frac_sum;
              ovf_nxt       = ovf_r || (|frac_sum[ACC_W-1:AMT_W]);
              frac_used_nxt = frac_used_r + FU_W'(1);
            end else if (is_blank) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_ERR;
            end
          end
          PH_TRAIL: begin
            if (!is_blank) begin
              phase_nxt = PH_ERR;
            end
          end
          default: begin
            phase_nxt = PH_ERR;
          end
        endcase
      end
    end
  end

  // Result of the string parsed so far, taken when a terminator arrives.
  always_comb begin
    result.amount = '0;
    priority if (phase_r == PH_ERR) begin
      result.status = dap_pkg::ST_BAD_CHAR;
    end else if (whole_count_r > WC_W'(MAX_WHOLE_DIGITS)) begin
      result.status = dap_pkg::ST_TOO_LONG;
    end else if (ovf_r) begin
      result.status = dap_pkg::ST_OVERFLOW;
    end else begin
      result.status = dap_pkg::ST_OK;
      result.amount = acc_r[AMT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEAD;
      acc_r         <= '0;
      ovf_r         <= 1'b0;
      whole_count_r <= '0;
      frac_used_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      acc_r         <= acc_nxt;
      ovf_r         <= ovf_nxt;
      whole_count_r <= whole_count_nxt;
      frac_used_r   <= frac_used_nxt;
      if (in_fire && in_data.terminator) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result register carries no reset; its valid flag guards it.
  always_ff @(posedge clk) begin
    if (in_fire && in_data.terminator) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
